// ===== hw/rtl/ttl_pkg.sv =====
// ----------------------------------------------------------------------------
// ttl_pkg
// Shared types and constants for the tick ledger controller: field widths,
// the reload mask, event and timer action codes, and the sequencer states.
// ----------------------------------------------------------------------------
package ttl_pkg;

    // Width of the timer reload register and of tick spans.
    localparam int RELOAD_W = 24;
    // Width of the cycles-per-tick register.
    localparam int CPT_W = RELOAD_W + 1;
    // Width of the wrapping expiry counters and of the deadline distance.
    localparam int CNT32_W = 32;
    // Iteration counter width for the serial units.
    localparam int ITER_W = $clog2(RELOAD_W);
    // Last iteration index of the serial units.
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(RELOAD_W - 1);
    // Largest reload value.
    localparam logic [RELOAD_W-1:0] RELOAD_MASK = {RELOAD_W{1'b1}};
    // A deadline at most this many ticks away does not arm a one-shot.
    localparam logic [CNT32_W-1:0] TICKLESS_THRESHOLD = CNT32_W'(2);

    // Stream word layout.
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 120;

    // Event codes carried in the input tuser.
    typedef enum logic [1:0] {
        CMD_EXPIRY = 2'd0,
        CMD_ARM    = 2'd1,
        CMD_WAKE   = 2'd2
    } t_cmd;

    // Timer actions reported with each result.
    typedef enum logic [1:0] {
        MODE_KEEP     = 2'd0,
        MODE_PERIODIC = 2'd1,
        MODE_ONESHOT  = 2'd2,
        MODE_STOP     = 2'd3
    } t_mode;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_CALC = 2'd1,
        ST_EMIT = 2'd2
    } t_state;

endpackage

// ===== hw/rtl/ttl_div.sv =====
// ----------------------------------------------------------------------------
// ttl_div
// Bit-serial restoring divider that finds how many whole ticks fit in the
// reload mask: quotient and remainder of RELOAD_MASK / divisor, one quotient
// bit per cycle, most significant first.
// ----------------------------------------------------------------------------
module ttl_div import ttl_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [CPT_W-1:0]    i_divisor,
    output logic                o_done,
    output logic [RELOAD_W-1:0] o_quot,
    output logic [CPT_W-1:0]    o_rem
);

    logic                r_busy;
    logic                r_done;
    logic [ITER_W-1:0]   r_iter;
    logic [CPT_W-1:0]    r_div;
    logic [CPT_W-1:0]    r_rem;
    logic [RELOAD_W-1:0] r_quot;

    logic [CPT_W:0]      trial;
    logic [CPT_W:0]      diff;
    logic                fits;

    // One restoring step: the dividend is all ones, so a one shifts in.
    always_comb begin
        trial = {r_rem, 1'b1};
        diff  = trial - {1'b0, r_div};
        fits  = (trial >= {1'b0, r_div});
    end

    // Control: run for one pass over the reload width.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_done <= r_busy && (r_iter == ITER_LAST);
            if (i_start) begin
                r_busy <= 1'b1;
                r_iter <= '0;
            end else if (r_busy) begin
                if (r_iter == ITER_LAST) begin
                    r_busy <= 1'b0;
                end
                r_iter <= r_iter + 1'b1;
            end
        end
    end

    // Datapath: partial remainder and quotient shift register.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div  <= i_divisor;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= fits ? diff[CPT_W-1:0] : trial[CPT_W-1:0];
            r_quot <= {r_quot[RELOAD_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

// ===== hw/rtl/ttl_mul.sv =====
// ----------------------------------------------------------------------------
// ttl_mul
// Bit-serial shift-and-add multiplier that forms the low reload-width bits of
// the deadline span times the tick length, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module ttl_mul import ttl_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [RELOAD_W-1:0] i_mcand,
    input  logic [RELOAD_W-1:0] i_mplier,
    output logic [RELOAD_W-1:0] o_prod
);

    logic                r_busy;
    logic [ITER_W-1:0]   r_iter;
    logic [RELOAD_W-1:0] r_mcand;
    logic [RELOAD_W-1:0] r_mplier;
    logic [RELOAD_W-1:0] r_acc;

    // Control: same pass length as the divider, so both finish together.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_iter <= '0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_iter <= '0;
            end else if (r_busy) begin
                if (r_iter == ITER_LAST) begin
                    r_busy <= 1'b0;
                end
                r_iter <= r_iter + 1'b1;
            end
        end
    end

    // Datapath: accumulator doubles and adds, most significant bit first.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand  <= i_mcand;
            r_mplier <= i_mplier;
            r_acc    <= '0;
        end else if (r_busy) begin
            r_acc    <= {r_acc[RELOAD_W-2:0], 1'b0}
                      + (r_mplier[RELOAD_W-1] ? r_mcand : '0);
            r_mplier <= {r_mplier[RELOAD_W-2:0], 1'b0};
        end
    end

    assign o_prod = r_acc;

endmodule

// ===== hw/rtl/tickless_tick_ledger.sv =====
// ----------------------------------------------------------------------------
// tickless_tick_ledger
// Tick ledger controller for a tickless-idle timer. Settles kernel ticks for
// expiry, arm and wake events and tells the timer how to run next.
//
//   Channel   Direction  Contents
//   s_axis    in         tuser: command; tdata: wrapped, deadline_pending, due
//   m_axis    out        tdata: elapsed, slice, mode, reload, totals
//   cfg       in         write enable and cycles-per-tick value
//
// An arm with a deadline past the threshold first runs the serial divider and
// multiplier, which each handle one reload bit per cycle; any other event goes
// straight to emit. A result moves to the output register once that register
// is free or being taken. One event is processed at a time; the next is
// accepted the cycle after the result has moved to the output register, which
// holds it until taken. Reset is synchronous and clears all ledger state.
// ----------------------------------------------------------------------------
module tickless_tick_ledger import ttl_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write.
    input  logic                  i_cfg_we,
    input  logic [CPT_W-1:0]      i_cfg_wdata,
    // Input events.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: wrapped [0], deadline_pending [1], due_ticks [33:2], zero fill
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: command [1:0]
    input  logic [1:0]            s_axis_tuser,
    // Results.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: elapsed_ticks [23:0], slice_tick [24], timer_mode [26:25],
    // reload_value [50:27], periodic_total [82:51], oneshot_total [114:83],
    // zero fill
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    t_state              r_state;
    t_state              n_state;

    // Latched event.
    logic [1:0]          r_cmd;
    logic                r_wrapped;
    logic                r_has_dl;
    logic [CNT32_W-1:0]  r_due;

    // Ledger state.
    logic [CPT_W-1:0]    r_cpt;
    logic [RELOAD_W-1:0] r_owed;
    logic [RELOAD_W-1:0] n_owed;
    logic [CNT32_W-1:0]  r_pcnt;
    logic [CNT32_W-1:0]  n_pcnt;
    logic [CNT32_W-1:0]  r_ocnt;
    logic [CNT32_W-1:0]  n_ocnt;

    // Output register.
    logic                r_ovalid;
    logic [RELOAD_W-1:0] r_elapsed;
    logic                r_slice;
    t_mode               r_mode;
    logic [RELOAD_W-1:0] r_reload;
    logic [CNT32_W-1:0]  r_ptot;
    logic [CNT32_W-1:0]  r_otot;

    // Result of the current event.
    logic [RELOAD_W-1:0] n_elapsed;
    logic                n_slice;
    t_mode               n_mode;
    logic [RELOAD_W-1:0] n_reload;

    // Sequencer controls.
    logic                accept;
    logic                need_calc;
    logic                start;
    logic                emit;

    // Serial unit results.
    logic                div_done;
    logic [RELOAD_W-1:0] quot;
    logic [CPT_W-1:0]    rem;
    logic [RELOAD_W-1:0] prod;

    // Span selection.
    logic                use_quot;
    logic [RELOAD_W-1:0] span;
    logic [RELOAD_W-1:0] span_cycles;
    logic [CPT_W-1:0]    per_reload_full;
    logic [RELOAD_W-1:0] per_reload;
    logic [CPT_W-1:0]    quot_cycles_full;

    // An arm with a far deadline needs the span and its length in cycles.
    assign need_calc = (t_cmd'(s_axis_tuser) == CMD_ARM) && (r_cpt != '0)
                     && s_axis_tdata[1]
                     && (s_axis_tdata[33:2] > TICKLESS_THRESHOLD);

    ttl_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_divisor (r_cpt),
        .o_done    (div_done),
        .o_quot    (quot),
        .o_rem     (rem)
    );

    ttl_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_mcand  (r_cpt[RELOAD_W-1:0]),
        .i_mplier (s_axis_tdata[RELOAD_W+1:2]),
        .o_prod   (prod)
    );

    // Clamp the span to what the reload register holds. A clamped span uses
    // the divider's remainder, a short one the multiplier's product.
    always_comb begin
        use_quot         = (|r_due[CNT32_W-1:RELOAD_W]) || (r_due[RELOAD_W-1:0] > quot);
        span             = use_quot ? quot : r_due[RELOAD_W-1:0];
        quot_cycles_full = {1'b0, RELOAD_MASK} - rem;
        span_cycles      = use_quot ? quot_cycles_full[RELOAD_W-1:0] : prod;
        per_reload_full  = r_cpt - CPT_W'(1);
        per_reload       = per_reload_full[RELOAD_W-1:0];
    end

    // Event decode: result fields and next ledger state.
    always_comb begin
        n_elapsed = '0;
        n_slice   = 1'b0;
        n_mode    = MODE_KEEP;
        n_reload  = '0;
        n_owed    = r_owed;
        n_pcnt    = r_pcnt;
        n_ocnt    = r_ocnt;
        unique case (r_cmd)
            CMD_EXPIRY: begin
                if (r_owed != '0) begin
                    n_elapsed = r_owed;
                    n_owed    = '0;
                    n_ocnt    = r_ocnt + 1'b1;
                    if (r_cpt != '0) begin
                        n_mode   = MODE_PERIODIC;
                        n_reload = per_reload;
                    end
                end else begin
                    n_pcnt    = r_pcnt + 1'b1;
                    n_elapsed = RELOAD_W'(1);
                    n_slice   = 1'b1;
                end
            end
            CMD_ARM: begin
                if (r_cpt != '0) begin
                    n_elapsed = RELOAD_W'(r_wrapped);
                    if (r_has_dl && (r_due > TICKLESS_THRESHOLD)) begin
                        if (span != '0) begin
                            n_owed   = span;
                            n_mode   = MODE_ONESHOT;
                            n_reload = span_cycles - 1'b1;
                        end
                    end else if (!r_has_dl) begin
                        n_mode = MODE_STOP;
                    end
                end
            end
            CMD_WAKE: begin
                if (r_cpt != '0) begin
                    if (r_owed != '0) begin
                        if (r_wrapped) begin
                            n_elapsed = r_owed;
                        end
                        n_owed = '0;
                    end else begin
                        n_elapsed = RELOAD_W'(r_wrapped);
                    end
                    n_mode   = MODE_PERIODIC;
                    n_reload = per_reload;
                end
            end
            default: begin
                n_elapsed = '0;
            end
        endcase
    end

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer next state and strobes.
    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        accept        = 1'b0;
        start         = 1'b0;
        emit          = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    accept  = 1'b1;
                    start   = need_calc;
                    n_state = need_calc ? ST_CALC : ST_EMIT;
                end
            end
            ST_CALC: begin
                if (div_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!r_ovalid || m_axis_tready) begin
                    emit    = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Event latch.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd     <= s_axis_tuser;
            r_wrapped <= s_axis_tdata[0];
            r_has_dl  <= s_axis_tdata[1];
            r_due     <= s_axis_tdata[33:2];
        end
    end

    // Configuration and ledger state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpt  <= '0;
            r_owed <= '0;
            r_pcnt <= '0;
            r_ocnt <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cpt <= i_cfg_wdata;
            end
            if (emit) begin
                r_owed <= n_owed;
                r_pcnt <= n_pcnt;
                r_ocnt <= n_ocnt;
            end
        end
    end

    // Output register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (emit) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_elapsed <= n_elapsed;
            r_slice   <= n_slice;
            r_mode    <= n_mode;
            r_reload  <= n_reload;
            r_ptot    <= n_pcnt;
            r_otot    <= n_ocnt;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {5'b0, r_otot, r_ptot, r_reload, r_mode, r_slice, r_elapsed};

endmodule
